// ===== hw/rtl/rdsc_pkg.sv =====
// Package for the row delete stream compactor: sizes, codes and the
// transaction structs shared by the top level and the deletion map.
// Depends on nothing.
package rdsc_pkg;

  // Sizing
  localparam int MAX_ROWS    = 4096;
  localparam int VALUE_WIDTH = 64;
  localparam int ADDR_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W       = $clog2(MAX_ROWS + 1);

  // Fixed field widths
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 13;
  localparam int VAL_W   = 64;
  localparam int KIND_W  = 2;
  localparam int DEST_W  = 12;
  localparam int KEPT_W  = 13;
  localparam int CFG_W   = 13;
  localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam logic [VAL_W-1:0] VALUE_MASK =
    (VALUE_WIDTH >= VAL_W) ? {VAL_W{1'b1}} :
                             ((VAL_W'(1) << VALUE_WIDTH) - VAL_W'(1));

  // Input modes
  localparam logic [MODE_W-1:0] MODE_BEGIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MARK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ROW   = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_KEPT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  row_index;
    logic              index_missing;
    logic [VAL_W-1:0]  row_value;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DEST_W-1:0] dest_index;
    logic [VAL_W-1:0]  out_value;
    logic [KEPT_W-1:0] kept_count;
    logic              last;
  } result_t;

  // Requests into the deletion map
  typedef struct packed {
    logic              clr_start;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } map_req_t;

  // Status out of the deletion map
  typedef struct packed {
    logic clr_busy;
    logic rd_data;
  } map_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM
  } state_e;

endpackage

// ===== hw/rtl/rdsc_map.sv =====
// Deletion map of the row delete stream compactor: one bit per row in a
// synchronous memory, with a clearing sweep after reset and on request.
// Depends on rdsc_pkg.
module rdsc_map (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rdsc_pkg::map_req_t req_i,
  output rdsc_pkg::map_rsp_t rsp_o
);

  logic                        mem [rdsc_pkg::MAX_ROWS];
  logic                        clr_busy_q, clr_busy_d;
  logic [rdsc_pkg::ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic                        rd_data_q;

  // Clearing sweep control: one entry per cycle
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == rdsc_pkg::ADDR_W'(rdsc_pkg::MAX_ROWS - 1)) begin
        clr_busy_d = 1'b0;
        clr_addr_d = '0;
      end
    end else if (req_i.clr_start) begin
      clr_busy_d = 1'b1;
      clr_addr_d = '0;
    end
  end

  // Sweep starts right out of reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Write port: the sweep has priority over marks
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= 1'b0;
    end else if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rsp_o.clr_busy = clr_busy_q;
  assign rsp_o.rd_data  = rd_data_q;

endmodule

// ===== hw/rtl/row_delete_stream_compactor.sv =====
// Top level of the row delete stream compactor: command channel, row
// counters, result register and the control state machine.
// Depends on rdsc_pkg and rdsc_map.
//
// Usage
//   An item is taken at a rising edge with start_i high and busy_o low.
//   A begin item clears the deletion map and the counters; mark items set a
//   row's deletion bit or raise an error result; row items stream one
//   column, each kept row coming out with its compacted destination index,
//   and a summary after the last row. row_count is written through
//   cfg_we_i / cfg_data_i; the user must write it only while the block is idle, the block itself does not enforce this.
// Timing
//   Mark: an error result is registered and shows in the cycle after acceptance.
//   Row: the map memory read is registered, then the result register; busy_o
//   stays high until the row is done, and the last row of a column that is
//   kept is followed by its summary from ST_SUM.
//   Begin: busy while the clearing sweep writes all MAX_ROWS (4096) map
//   entries, one per cycle. The same sweep runs after reset.
// Results
//   Each result is on result_o for exactly one cycle with result_valid_o
//   high; the receiver cannot stall, so nothing is held back.
module row_delete_stream_compactor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  rdsc_pkg::item_t               item_i,
  output logic                          result_valid_o,
  output rdsc_pkg::result_t             result_o,
  input  logic                          cfg_we_i,
  input  logic [rdsc_pkg::CFG_W-1:0]    cfg_data_i
);

  rdsc_pkg::state_e            state_q, state_d;
  logic [rdsc_pkg::CNT_W-1:0]  pos_q, pos_d;
  logic [rdsc_pkg::CNT_W-1:0]  dest_q, dest_d;
  logic [rdsc_pkg::CFG_W-1:0]  row_count_q;
  logic [rdsc_pkg::VAL_W-1:0]  val_q, val_d;
  logic                        res_valid_q, res_valid_d;
  rdsc_pkg::result_t           res_q, res_d;

  rdsc_pkg::map_req_t          map_req;
  rdsc_pkg::map_rsp_t          map_rsp;

  logic                        accept;
  logic [rdsc_pkg::CNT_W-1:0]  n_rows;
  logic [rdsc_pkg::CNT_W-1:0]  pos_eff;
  logic [rdsc_pkg::CNT_W-1:0]  pos_nxt;
  logic                        row_kept;
  logic                        last_row;

  rdsc_map u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (map_req),
    .rsp_o  (map_rsp)
  );

  // Effective row count, saturated at the map depth
  always_comb begin
    if (rdsc_pkg::CMP_W'(row_count_q) > rdsc_pkg::CMP_W'(rdsc_pkg::MAX_ROWS)) begin
      n_rows = rdsc_pkg::CNT_W'(rdsc_pkg::MAX_ROWS);
    end else begin
      n_rows = rdsc_pkg::CNT_W'(row_count_q);
    end
  end

  assign busy_o   = (state_q != rdsc_pkg::ST_IDLE) || map_rsp.clr_busy;
  assign accept   = start_i && !busy_o;
  // Stale position after row_count was lowered restarts the column
  assign pos_eff  = (pos_q >= n_rows) ? '0 : pos_q;
  assign pos_nxt  = pos_q + 1'b1;
  assign row_kept = !map_rsp.rd_data;
  assign last_row = (pos_nxt == n_rows);

  // Next state, map requests and result
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    dest_d      = dest_q;
    val_d       = val_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    map_req     = '0;

    case (state_q)
      rdsc_pkg::ST_IDLE: begin
        if (accept) begin
          case (item_i.mode)
            rdsc_pkg::MODE_BEGIN: begin
              map_req.clr_start = 1'b1;
              pos_d             = '0;
              dest_d            = '0;
            end
            rdsc_pkg::MODE_MARK: begin
              if (!item_i.index_missing) begin
                if ((item_i.row_index == '0) ||
                    (rdsc_pkg::CMP_W'(item_i.row_index) > rdsc_pkg::CMP_W'(n_rows))) begin
                  res_valid_d = 1'b1;
                  res_d.kind  = rdsc_pkg::KIND_ERROR;
                  res_d.last  = 1'b1;
                end else begin
                  map_req.wr_en   = 1'b1;
                  map_req.wr_addr = rdsc_pkg::ADDR_W'(item_i.row_index - 1'b1);
                end
              end
            end
            rdsc_pkg::MODE_ROW: begin
              if (n_rows != '0) begin
                map_req.rd_en   = 1'b1;
                map_req.rd_addr = rdsc_pkg::ADDR_W'(pos_eff);
                pos_d           = pos_eff;
                dest_d          = (pos_q >= n_rows) ? '0 : dest_q;
                val_d           = item_i.row_value & rdsc_pkg::VALUE_MASK;
                state_d         = rdsc_pkg::ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Map bit is in: emit kept row or the summary of a deleted last row
      rdsc_pkg::ST_READ: begin
        state_d = rdsc_pkg::ST_IDLE;
        if (row_kept) begin
          res_valid_d      = 1'b1;
          res_d.kind       = rdsc_pkg::KIND_KEPT;
          res_d.dest_index = rdsc_pkg::DEST_W'(dest_q);
          res_d.out_value  = val_q;
          res_d.last       = !last_row;
          dest_d           = dest_q + 1'b1;
        end
        if (last_row) begin
          if (row_kept) begin
            state_d = rdsc_pkg::ST_SUM;
          end else begin
            res_valid_d      = 1'b1;
            res_d.kind       = rdsc_pkg::KIND_SUMMARY;
            res_d.kept_count = rdsc_pkg::KEPT_W'(dest_q);
            res_d.last       = 1'b1;
            pos_d            = '0;
            dest_d           = '0;
          end
        end else begin
          pos_d = pos_nxt;
        end
      end

      // Summary after a kept last row
      rdsc_pkg::ST_SUM: begin
        res_valid_d      = 1'b1;
        res_d.kind       = rdsc_pkg::KIND_SUMMARY;
        res_d.kept_count = rdsc_pkg::KEPT_W'(dest_q);
        res_d.last       = 1'b1;
        pos_d            = '0;
        dest_d           = '0;
        state_d          = rdsc_pkg::ST_IDLE;
      end

      default: begin
        state_d = rdsc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rdsc_pkg::ST_IDLE;
      pos_q       <= '0;
      dest_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      dest_q      <= dest_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= '0;
    end else if (cfg_we_i) begin
      row_count_q <= cfg_data_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule
